/* hdl/prp_pkg.sv */
// ----------------------------------------------------------------------------
// prp_pkg: shared types and constants of the PageRank CSR push engine
// Field widths, item codes, datapath operation codes and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

  // Item field widths
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 10;
  localparam int VALUE_W = 11;
  localparam int NODE_W  = 7;
  localparam int RANK_W  = 32;
  localparam int ITER_W  = 16;
  localparam int DAMP_W  = 16;
  localparam int NCNT_W  = 8;
  localparam int TOL_W   = 40;
  localparam int CFGI_W  = 2;

  // Input item modes
  localparam logic [MODE_W-1:0] MODE_ROW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SCORE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_DAMPING   = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_NODES     = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_ITER_LIM  = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_TOLERANCE = 2'd3;

  // Datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD_ROW  = 5'd1;
  localparam logic [OP_W-1:0] OP_LOAD_EDGE = 5'd2;
  localparam logic [OP_W-1:0] OP_RD_SCORE  = 5'd3;
  localparam logic [OP_W-1:0] OP_READ_OUT  = 5'd4;
  localparam logic [OP_W-1:0] OP_RUN_START = 5'd5;
  localparam logic [OP_W-1:0] OP_INIT_GOT  = 5'd6;
  localparam logic [OP_W-1:0] OP_BASE_GOT  = 5'd7;
  localparam logic [OP_W-1:0] OP_FILL_OLD  = 5'd8;
  localparam logic [OP_W-1:0] OP_FILL_NEW  = 5'd9;
  localparam logic [OP_W-1:0] OP_ROW_RD    = 5'd10;
  localparam logic [OP_W-1:0] OP_ROW_GOT   = 5'd11;
  localparam logic [OP_W-1:0] OP_DIV_PUSH  = 5'd12;
  localparam logic [OP_W-1:0] OP_PUSH_GOT  = 5'd13;
  localparam logic [OP_W-1:0] OP_EDGE_RD   = 5'd14;
  localparam logic [OP_W-1:0] OP_EDGE_GOT  = 5'd15;
  localparam logic [OP_W-1:0] OP_NEW_ADD   = 5'd16;
  localparam logic [OP_W-1:0] OP_NEXT_U    = 5'd17;
  localparam logic [OP_W-1:0] OP_DIFF_RD   = 5'd18;
  localparam logic [OP_W-1:0] OP_DIFF_MUL  = 5'd19;
  localparam logic [OP_W-1:0] OP_DIFF_ACC  = 5'd20;
  localparam logic [OP_W-1:0] OP_CHECK     = 5'd21;
  localparam logic [OP_W-1:0] OP_COPY_RD   = 5'd22;
  localparam logic [OP_W-1:0] OP_COPY_WR   = 5'd23;
  localparam logic [OP_W-1:0] OP_STAT_OUT  = 5'd24;

  // Controller to datapath
  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic div_busy;
    logic div_done;
    logic u_last;
    logic k_last;
    logic deg_empty;
    logic conv;
    logic it_last;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/prp_div.sv */
// ----------------------------------------------------------------------------
// prp_div: shared restoring divider
// Divides a 33-bit dividend by a narrow non-zero divisor, one quotient bit
// per cycle, and gives the quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_div import prp_pkg::*; #(
  parameter int DVW = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [32:0]      dividend,
  input  wire logic [DVW-1:0]   divisor,
  output logic                  busy,
  output logic                  done,
  output logic [RANK_W-1:0]     quotient
);

  logic [32:0]    quo_r, quo_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] dvs_r;
  logic [5:0]     cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DVW:0]   trial;
  logic           fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial    = {rem_r, quo_r[32]};
    fits     = (trial >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DVW'(trial - {1'b0, dvs_r}) : trial[DVW-1:0];
      quo_nxt = {quo_r[31:0], fits};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r[32] ? {RANK_W{1'b1}} : quo_r[31:0];

endmodule

`default_nettype wire

/* hdl/prp_datapath.sv */
// ----------------------------------------------------------------------------
// prp_datapath: tables, score memories and arithmetic of the PageRank engine
// Holds the configuration registers, the CSR tables, both score memories,
// the counters, the multipliers, the shared divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_datapath import prp_pkg::*; #(
  parameter int MAX_NODES = 128,
  parameter int MAX_EDGES = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CFGI_W-1:0]   cfg_index,
  input  wire logic [TOL_W-1:0]    cfg_wdata,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire logic [VALUE_W-1:0]  in_value,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_kind,
  output logic [NODE_W-1:0]        out_node,
  output logic [RANK_W-1:0]        out_rank,
  output logic [ITER_W-1:0]        out_iter,
  output logic                     out_conv
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int OW  = $clog2(MAX_EDGES + 1);
  localparam int AW  = TOL_W + NCW;
  localparam int DVW = (OW > NCW) ? OW : NCW;

  // Configuration registers
  logic [DAMP_W-1:0] damp_r;
  logic [NCNT_W-1:0] ncnt_r;
  logic [ITER_W-1:0] lim_r;
  logic [TOL_W-1:0]  tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r <= DAMP_W'(55706);
      ncnt_r <= NCNT_W'(100);
      lim_r  <= ITER_W'(1000);
      tol_r  <= TOL_W'(1099512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DAMPING:   damp_r <= cfg_wdata[DAMP_W-1:0];
        CFG_NODES:     ncnt_r <= cfg_wdata[NCNT_W-1:0];
        CFG_ITER_LIM:  lim_r  <= cfg_wdata[ITER_W-1:0];
        CFG_TOLERANCE: tol_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective node count and iteration limit
  logic [31:0]   n_w32;
  logic [NCW-1:0] n_cur;
  logic [ITER_W:0] lim_eff;
  assign n_w32 = (ncnt_r == '0) ? 32'd1 :
                 ((32'(ncnt_r) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(ncnt_r));
  assign n_cur   = n_w32[NCW-1:0];
  assign lim_eff = (lim_r == '0) ? (ITER_W+1)'(1) : {1'b0, lim_r};

  // Item fields widened for range checks
  logic [31:0] slot32, value32, vclamp32;
  assign slot32   = 32'(in_slot);
  assign value32  = 32'(in_value);
  assign vclamp32 = (value32 > 32'(MAX_EDGES)) ? 32'(MAX_EDGES) : value32;

  // Memories
  logic [OW-1:0]      row_mem  [0:MAX_NODES];
  logic [VALUE_W-1:0] edge_mem [0:MAX_EDGES-1];
  logic [RANK_W-1:0]  old_mem  [0:MAX_NODES-1];
  logic [RANK_W-1:0]  new_mem  [0:MAX_NODES-1];

  logic [OW-1:0]      row_a_rd_r, row_b_rd_r;
  logic [VALUE_W-1:0] edge_rd_r;
  logic [RANK_W-1:0]  old_rd_r, new_rd_r;

  // Run registers
  logic [NCW-1:0]    u_r;
  logic [OW-1:0]     k_r, s_r, e_r;
  logic [RANK_W-1:0] init_r, base_r, push_r;
  logic [47:0]       prod_r;
  logic [63:0]       sq_r;
  logic [AW-1:0]     acc_r;
  logic [NW-1:0]     v_r;
  logic              v_ok_r;
  logic [SLOT_W-1:0] slot_r;
  logic              rd_ok_r;
  logic [ITER_W-1:0] iter_cnt_r;
  logic              done_flag_r;

  logic [31:0]       tgt32;
  logic [NCW-1:0]    u_step;
  logic              u_last;
  logic [RANK_W:0]   new_sum;
  logic [RANK_W-1:0] new_sat;
  logic [RANK_W-1:0] abs_d;
  logic [TOL_W-1:0]  diff_sat;

  assign tgt32    = 32'(edge_rd_r);
  assign u_last   = (u_r == (n_cur - NCW'(1)));
  assign u_step   = u_last ? '0 : (u_r + NCW'(1));
  assign new_sum  = {1'b0, new_rd_r} + {1'b0, push_r};
  assign new_sat  = new_sum[RANK_W] ? {RANK_W{1'b1}} : new_sum[RANK_W-1:0];
  assign abs_d    = (new_rd_r > old_rd_r) ? (new_rd_r - old_rd_r) : (old_rd_r - new_rd_r);
  assign diff_sat = (acc_r > AW'({TOL_W{1'b1}})) ? {TOL_W{1'b1}} : acc_r[TOL_W-1:0];

  // Table loads and CSR reads
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_ROW && slot32 <= 32'(MAX_NODES)) begin
      row_mem[slot32[NCW-1:0]] <= vclamp32[OW-1:0];
    end
    if (cmd.op == OP_LOAD_EDGE && slot32 < 32'(MAX_EDGES)) begin
      edge_mem[slot32[EAW-1:0]] <= in_value;
    end
    if (cmd.op == OP_ROW_RD) begin
      row_a_rd_r <= row_mem[u_r];
      row_b_rd_r <= row_mem[u_r + NCW'(1)];
    end
    if (cmd.op == OP_EDGE_RD) begin
      edge_rd_r <= edge_mem[k_r[EAW-1:0]];
    end
  end

  // Old score memory: seeded at run start, refreshed after each iteration
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FILL_OLD) begin
      old_mem[u_r[NW-1:0]] <= init_r;
    end else if (cmd.op == OP_COPY_WR) begin
      old_mem[u_r[NW-1:0]] <= new_rd_r;
    end
    if (cmd.op == OP_ROW_RD || cmd.op == OP_DIFF_RD) begin
      old_rd_r <= old_mem[u_r[NW-1:0]];
    end
  end

  // New score memory: one read address chosen by the operation
  logic [NW-1:0] new_ra;
  logic          new_re;
  always_comb begin
    new_re = 1'b1;
    new_ra = u_r[NW-1:0];
    case (cmd.op)
      OP_RD_SCORE: new_ra = slot32[NW-1:0];
      OP_EDGE_GOT: new_ra = tgt32[NW-1:0];
      OP_DIFF_RD, OP_COPY_RD: new_ra = u_r[NW-1:0];
      default: new_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FILL_NEW) begin
      new_mem[u_r[NW-1:0]] <= base_r;
    end else if (cmd.op == OP_NEW_ADD && v_ok_r) begin
      new_mem[v_r] <= new_sat;
    end
    if (new_re) begin
      new_rd_r <= new_mem[new_ra];
    end
  end

  // Shared divider
  logic             div_start;
  logic [32:0]      div_dvd;
  logic [DVW-1:0]   div_dvs;
  logic             div_busy, div_done;
  logic [RANK_W-1:0] div_q;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = 33'h1_0000_0000;
    div_dvs   = DVW'(n_cur);
    case (cmd.op)
      OP_RUN_START: div_start = 1'b1;
      OP_INIT_GOT: begin
        div_start = 1'b1;
        div_dvd   = {(17'h1_0000 - {1'b0, damp_r}), 16'h0000};
      end
      OP_DIV_PUSH: begin
        div_start = 1'b1;
        div_dvd   = {1'b0, prod_r[47:16]};
        div_dvs   = DVW'(e_r - s_r);
      end
      default: ;
    endcase
  end

  prp_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Run sequencing registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RD_SCORE: begin
        slot_r  <= in_slot;
        rd_ok_r <= (slot32 < 32'(n_cur));
      end
      OP_INIT_GOT: init_r <= div_q;
      OP_BASE_GOT: begin
        base_r <= div_q;
        u_r    <= '0;
      end
      OP_FILL_OLD, OP_NEXT_U, OP_DIFF_ACC, OP_COPY_WR: u_r <= u_step;
      OP_FILL_NEW: begin
        u_r   <= u_step;
        acc_r <= '0;
      end
      OP_ROW_GOT: begin
        s_r    <= row_a_rd_r;
        e_r    <= row_b_rd_r;
        k_r    <= row_a_rd_r;
        prod_r <= 48'(damp_r) * 48'(old_rd_r);
      end
      OP_PUSH_GOT: push_r <= div_q;
      OP_EDGE_GOT: begin
        v_r    <= tgt32[NW-1:0];
        v_ok_r <= (tgt32 < 32'(n_cur));
      end
      OP_NEW_ADD: k_r <= k_r + OW'(1);
      OP_DIFF_MUL: sq_r <= 64'(abs_d) * 64'(abs_d);
      OP_CHECK: u_r <= '0;
      default: ;
    endcase
    if (cmd.op == OP_DIFF_ACC) begin
      acc_r <= acc_r + AW'(sq_r[63:24]);
    end
  end

  // Run outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_cnt_r  <= '0;
      done_flag_r <= 1'b0;
    end else if (cmd.op == OP_RUN_START) begin
      iter_cnt_r  <= '0;
      done_flag_r <= 1'b0;
    end else if (cmd.op == OP_CHECK) begin
      iter_cnt_r <= iter_cnt_r + ITER_W'(1);
      if (diff_sat < tol_r) begin
        done_flag_r <= 1'b1;
      end
    end
  end

  // Result register
  logic              ovalid_r;
  logic              okind_r;
  logic [NODE_W-1:0] onode_r;
  logic [RANK_W-1:0] orank_r;
  logic [ITER_W-1:0] oiter_r;
  logic              oconv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.op == OP_READ_OUT || cmd.op == OP_STAT_OUT) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_READ_OUT) begin
      okind_r <= KIND_SCORE;
      onode_r <= slot_r[NODE_W-1:0];
      orank_r <= rd_ok_r ? new_rd_r : '0;
      oiter_r <= iter_cnt_r;
      oconv_r <= done_flag_r;
    end else if (cmd.op == OP_STAT_OUT) begin
      okind_r <= KIND_STATUS;
      onode_r <= '0;
      orank_r <= '0;
      oiter_r <= iter_cnt_r;
      oconv_r <= done_flag_r;
    end
  end

  assign out_valid = ovalid_r;
  assign out_kind  = okind_r;
  assign out_node  = onode_r;
  assign out_rank  = orank_r;
  assign out_iter  = oiter_r;
  assign out_conv  = oconv_r;

  // Status to the controller
  always_comb begin
    sts.out_free  = !ovalid_r || out_ready;
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.u_last    = u_last;
    sts.k_last    = (k_r == (e_r - OW'(1)));
    sts.deg_empty = (e_r <= s_r);
    sts.conv      = (diff_sat < tol_r);
    sts.it_last   = (({1'b0, iter_cnt_r} + (ITER_W+1)'(1)) >= lim_eff);
  end

endmodule

`default_nettype wire

/* hdl/prp_ctrl.sv */
// ----------------------------------------------------------------------------
// prp_ctrl: sequencer of the PageRank engine
// Accepts input transactions when idle and steps the datapath through the
// seeding, push, squared-change and copy phases of each iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_ctrl import prp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] in_mode,
  output logic                   in_ready,
  input  wire sts_t              sts,
  output cmd_t                   cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_READ     = 5'd1;
  localparam logic [4:0] S_DIV_I    = 5'd2;
  localparam logic [4:0] S_DIV_B    = 5'd3;
  localparam logic [4:0] S_FILL_OLD = 5'd4;
  localparam logic [4:0] S_FILL_NEW = 5'd5;
  localparam logic [4:0] S_ROW      = 5'd6;
  localparam logic [4:0] S_ROW_W    = 5'd7;
  localparam logic [4:0] S_ROW_D    = 5'd8;
  localparam logic [4:0] S_PUSH_W   = 5'd9;
  localparam logic [4:0] S_EDGE_A   = 5'd10;
  localparam logic [4:0] S_EDGE_D   = 5'd11;
  localparam logic [4:0] S_NEW_D    = 5'd12;
  localparam logic [4:0] S_NEXT_U   = 5'd13;
  localparam logic [4:0] S_DIFF_A   = 5'd14;
  localparam logic [4:0] S_DIFF_D   = 5'd15;
  localparam logic [4:0] S_DIFF_S   = 5'd16;
  localparam logic [4:0] S_CHECK    = 5'd17;
  localparam logic [4:0] S_COPY_A   = 5'd18;
  localparam logic [4:0] S_COPY_W   = 5'd19;
  localparam logic [4:0] S_FIN      = 5'd20;

  logic [4:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath operation
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_ROW:  cmd.op = OP_LOAD_ROW;
            MODE_EDGE: cmd.op = OP_LOAD_EDGE;
            MODE_RUN: begin
              cmd.op    = OP_RUN_START;
              state_nxt = S_DIV_I;
            end
            default: begin
              cmd.op    = OP_RD_SCORE;
              state_nxt = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.op    = OP_READ_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_DIV_I: begin
        if (sts.div_done) begin
          cmd.op    = OP_INIT_GOT;
          state_nxt = S_DIV_B;
        end
      end
      S_DIV_B: begin
        if (sts.div_done) begin
          cmd.op    = OP_BASE_GOT;
          state_nxt = S_FILL_OLD;
        end
      end
      S_FILL_OLD: begin
        cmd.op = OP_FILL_OLD;
        if (sts.u_last) state_nxt = S_FILL_NEW;
      end
      S_FILL_NEW: begin
        cmd.op = OP_FILL_NEW;
        if (sts.u_last) state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.op    = OP_ROW_RD;
        state_nxt = S_ROW_W;
      end
      S_ROW_W: begin
        cmd.op    = OP_ROW_GOT;
        state_nxt = S_ROW_D;
      end
      S_ROW_D: begin
        if (sts.deg_empty) begin
          state_nxt = S_NEXT_U;
        end else begin
          cmd.op    = OP_DIV_PUSH;
          state_nxt = S_PUSH_W;
        end
      end
      S_PUSH_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_PUSH_GOT;
          state_nxt = S_EDGE_A;
        end
      end
      S_EDGE_A: begin
        cmd.op    = OP_EDGE_RD;
        state_nxt = S_EDGE_D;
      end
      S_EDGE_D: begin
        cmd.op    = OP_EDGE_GOT;
        state_nxt = S_NEW_D;
      end
      S_NEW_D: begin
        cmd.op    = OP_NEW_ADD;
        state_nxt = sts.k_last ? S_NEXT_U : S_EDGE_A;
      end
      S_NEXT_U: begin
        cmd.op    = OP_NEXT_U;
        state_nxt = sts.u_last ? S_DIFF_A : S_ROW;
      end
      S_DIFF_A: begin
        cmd.op    = OP_DIFF_RD;
        state_nxt = S_DIFF_D;
      end
      S_DIFF_D: begin
        cmd.op    = OP_DIFF_MUL;
        state_nxt = S_DIFF_S;
      end
      S_DIFF_S: begin
        cmd.op    = OP_DIFF_ACC;
        state_nxt = sts.u_last ? S_CHECK : S_DIFF_A;
      end
      S_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = (sts.conv || sts.it_last) ? S_FIN : S_COPY_A;
      end
      S_COPY_A: begin
        cmd.op    = OP_COPY_RD;
        state_nxt = S_COPY_W;
      end
      S_COPY_W: begin
        cmd.op    = OP_COPY_WR;
        state_nxt = sts.u_last ? S_FILL_NEW : S_COPY_A;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op    = OP_STAT_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/pagerank_csr_push.sv */
// ----------------------------------------------------------------------------
// pagerank_csr_push: PageRank power iteration over a CSR graph
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions carry a mode in in_tuser and slot and value in
//   in_tdata. Row offset and edge target writes give no result. A score
//   read gives one readout. A run gives one status result when it
//   finishes.
//   A run divides out the seed and base scores, then per iteration seeds
//   the new scores, divides each node's push in the shared bit-serial
//   divider when it has out-edges, reads the edge table, reads and writes
//   back a score per edge, sums the squared change and copies the scores.
//   in_tready is high only while the sequencer is idle, so one item is at
//   work at a time; load items follow back to back.
//   Results sit in an output register; a stalled receiver holds the result
//   while the next item is still accepted, and the following result waits
//   until the register is taken.
//   The cfg_ port writes damping (0), node count (1), iteration limit (2)
//   and tolerance (3); the user writes them only while the block is idle (unchecked).
//   Synchronous reset restores the register defaults, clears the run outcome
//   and empties the output register; the tables stay unwritten.
// ----------------------------------------------------------------------------
`default_nettype none

module pagerank_csr_push import prp_pkg::*; #(
  parameter int MAX_NODES = 128,
  parameter int MAX_EDGES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFGI_W-1:0] cfg_index,
  input  wire logic [TOL_W-1:0]  cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [23:0]       in_tdata,   // slot[9:0], value[20:10], zero
  input  wire logic [1:0]        in_tuser,   // mode[1:0]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [55:0]            out_tdata,  // node, rank, iterations, converged
  output logic [0:0]             out_tuser   // kind
);

  cmd_t cmd;
  sts_t sts;

  logic              o_kind;
  logic [NODE_W-1:0] o_node;
  logic [RANK_W-1:0] o_rank;
  logic [ITER_W-1:0] o_iter;
  logic              o_conv;

  prp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prp_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_slot   (in_tdata[9:0]),
    .in_value  (in_tdata[20:10]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (o_kind),
    .out_node  (o_node),
    .out_rank  (o_rank),
    .out_iter  (o_iter),
    .out_conv  (o_conv)
  );

  assign out_tdata = {o_conv, o_iter, o_rank, o_node};
  assign out_tuser = o_kind;

  // A run transaction takes the sequencer out of idle.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == MODE_RUN) |=> !in_tready)
    else $error("sequencer stayed idle after a run transaction");

  // The divider is never restarted while it is still working on a push.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV_PUSH) |-> !sts.div_busy)
    else $error("divider started while busy");

  // A result is only loaded into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_READ_OUT || cmd.op == OP_STAT_OUT) |-> sts.out_free)
    else $error("result overwrote a pending transaction");

endmodule

`default_nettype wire

/* sim/tb_pagerank_csr_push.sv */
// ----------------------------------------------------------------------------
// tb_pagerank_csr_push: self-checking testbench for the PageRank CSR engine
// Loads small CSR graphs, runs power iterations and reads back the scores.
// A behavioural predictor computes every status and readout. A checker
// compares each output transaction with the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_pagerank_csr_push;
  import prp_pkg::*;

  localparam int NODES_MAX  = 128;
  localparam int EDGES_MAX  = 1024;
  localparam int STALL_LIMIT = 300000;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] val;
  } graph_item_t;

  typedef struct {
    logic              kind;
    logic [NODE_W-1:0] node;
    logic [RANK_W-1:0] rank;
    logic [ITER_W-1:0] iters;
    logic              conv;
  } rank_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [TOL_W-1:0]  cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [55:0]       out_tdata;
  logic [0:0]        out_tuser;

  pagerank_csr_push uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // Predictor state: registers, tables and outcome of the last run.
  logic [DAMP_W-1:0]  damp_reg;
  logic [NCNT_W-1:0]  nodes_reg;
  logic [ITER_W-1:0]  limit_reg;
  logic [TOL_W-1:0]   tol_reg;
  logic [VALUE_W-1:0] row_tab [NODES_MAX+1];
  logic [VALUE_W-1:0] tgt_tab [EDGES_MAX];
  logic [RANK_W-1:0]  old_rank [NODES_MAX];
  logic [RANK_W-1:0]  new_rank [NODES_MAX];
  logic [ITER_W-1:0]  last_iters;
  logic               last_conv;

  graph_item_t  stim_q[$];
  rank_result_t pending_results[$];
  int           errors = 0;
  bit           quiet = 1'b0;
  bit           took = 1'b0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           idle_cycles = 0;
  // Planning mirrors, used to keep every run and read within the contract.
  int           plan_nodes;
  int           scores_hi = 0;

  function automatic int used_nodes(int raw);
    if (raw == 0) return 1;
    if (raw > NODES_MAX) return NODES_MAX;
    return raw;
  endfunction

  function automatic logic [31:0] sat32(longint unsigned x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic int clamp_off(int x);
    return (x > EDGES_MAX) ? EDGES_MAX : x;
  endfunction

  // Push-style power iteration in fixed point, truncating and saturating.
  function automatic void iterate_ranks();
    int unsigned n, lim, u, k, s, e, deg, step;
    longint unsigned seed, base, push, diff, a, b, d;
    n = used_nodes(nodes_reg);
    lim = (limit_reg == 0) ? 1 : limit_reg;
    seed = sat32(64'h1_0000_0000 / n);
    base = sat32(((64'd65536 - damp_reg) << 16) / n);
    for (u = 0; u < n; u++) old_rank[u] = seed;
    last_iters = 0;
    last_conv = 1'b0;
    for (step = 0; step < lim; step++) begin
      diff = 0;
      for (u = 0; u < n; u++) new_rank[u] = base;
      for (u = 0; u < n; u++) begin
        s = clamp_off(row_tab[u]);
        e = clamp_off(row_tab[u+1]);
        if (e > s) begin
          deg = e - s;
          push = ((longint'(damp_reg) * old_rank[u]) >> 16) / deg;
          for (k = s; k < e; k++)
            if (tgt_tab[k] < n)
              new_rank[tgt_tab[k]] = sat32(longint'(new_rank[tgt_tab[k]]) + push);
        end
      end
      for (u = 0; u < n; u++) begin
        a = new_rank[u];
        b = old_rank[u];
        d = (a > b) ? a - b : b - a;
        diff += (d * d) >> 24;
      end
      if (diff > 64'hFF_FFFF_FFFF) diff = 64'hFF_FFFF_FFFF;
      last_iters = step + 1;
      if (diff < tol_reg) begin
        last_conv = 1'b1;
        break;
      end
      for (u = 0; u < n; u++) old_rank[u] = new_rank[u];
    end
  endfunction

  // Applies one accepted input transaction to the predictor.
  function automatic void predict_item(logic [1:0] mode, logic [9:0] slot,
                                       logic [10:0] val);
    rank_result_t r;
    case (mode)
      MODE_ROW:  if (slot <= NODES_MAX) row_tab[slot] = val;
      MODE_EDGE: tgt_tab[slot] = val;
      MODE_RUN: begin
        iterate_ranks();
        r = '{KIND_STATUS, '0, '0, last_iters, last_conv};
        pending_results.push_back(r);
      end
      default: begin
        r.kind = KIND_SCORE;
        r.node = slot[6:0];
        r.rank = (slot < used_nodes(nodes_reg)) ? new_rank[slot] : '0;
        r.iters = last_iters;
        r.conv = last_conv;
        pending_results.push_back(r);
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, longint unsigned got,
                                 longint unsigned want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
             got, want);
    errors++;
  endtask

  // Input transactions feed the predictor; output transactions are checked.
  always @(posedge clk) begin
    rank_result_t want;
    took = rst_n && in_tvalid && in_tready;
    if (took) predict_item(in_tuser, in_tdata[9:0], in_tdata[20:10]);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected output transaction", $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[6:0] !== want.node) report_mismatch("node", out_tdata[6:0], want.node);
        if (out_tdata[38:7] !== want.rank) report_mismatch("rank", out_tdata[38:7], want.rank);
        if (out_tdata[54:39] !== want.iters)
          report_mismatch("iterations", out_tdata[54:39], want.iters);
        if (out_tdata[55] !== want.conv) report_mismatch("converged", out_tdata[55], want.conv);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender: one assignment per falling edge, gaps come in random bursts.
  always @(negedge clk) begin
    graph_item_t it;
    if (rst_n && (!in_tvalid || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        it = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.mode;
        in_tdata <= {3'b000, it.val, it.slot};
        if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 10);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic queue_item(logic [1:0] mode, int slot, int val);
    graph_item_t it;
    it = '{mode, slot[9:0], val[10:0]};
    if (mode == MODE_RUN && used_nodes(plan_nodes) > scores_hi)
      scores_hi = used_nodes(plan_nodes);
    stim_q.push_back(it);
  endtask

  // Waits until every item is taken and every result has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (stim_q.size() != 0 || in_tvalid || pending_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFGI_W-1:0] idx, logic [TOL_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_DAMPING:  damp_reg = data[15:0];
      CFG_NODES: begin
        nodes_reg = data[7:0];
        plan_nodes = data[7:0];
      end
      CFG_ITER_LIM: limit_reg = data[15:0];
      default:      tol_reg = data;
    endcase
  endtask

  // Writes every row offset up to n and every edge that those rows cover.
  task automatic load_graph(int n, int max_deg);
    int offs[NODES_MAX+1];
    int u, k, cur;
    cur = ($urandom_range(0, 7) == 0) ? $urandom_range(990, 1030) : $urandom_range(0, 200);
    for (u = 0; u <= n; u++) begin
      if (u > 0 && $urandom_range(0, 7) == 0) offs[u] = (cur > 3) ? cur - 3 : 0;
      else begin
        if (u > 0) cur += $urandom_range(0, max_deg);
        offs[u] = cur;
      end
      queue_item(MODE_ROW, u, offs[u]);
    end
    for (u = 0; u < n; u++)
      for (k = clamp_off(offs[u]); k < clamp_off(offs[u+1]); k++)
        queue_item(MODE_EDGE, k, ($urandom_range(0, 9) == 0) ?
                   $urandom_range(n, 2047) : $urandom_range(0, n - 1));
  endtask

  task automatic queue_reads(int count);
    int slot;
    repeat (count) begin
      slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                         : $urandom_range(0, used_nodes(plan_nodes) - 1);
      if (slot >= scores_hi && slot < used_nodes(plan_nodes)) slot = 0;
      queue_item(MODE_READ, slot, $urandom_range(0, 2047));
    end
  endtask

  // Reset values of damping, limit and tolerance on a three-node ring.
  task automatic test_default_regs();
    write_reg(CFG_NODES, 3);
    for (int u = 0; u <= 3; u++) queue_item(MODE_ROW, u, u);
    for (int k = 0; k < 3; k++) queue_item(MODE_EDGE, k, (k + 1) % 3);
    queue_item(MODE_RUN, 0, 0);
    for (int u = 0; u < 3; u++) queue_item(MODE_READ, u, 0);
    wait_idle();
  endtask

  // Saturating scores, clamped offsets, dropped pushes and ignored writes.
  task automatic test_corner_cases();
    write_reg(CFG_NODES, 0);
    write_reg(CFG_DAMPING, 0);
    write_reg(CFG_ITER_LIM, 0);
    write_reg(CFG_TOLERANCE, 40'hFF_FFFF_FFFF);
    queue_item(MODE_ROW, 0, 1022);
    queue_item(MODE_ROW, 1, 2047);
    queue_item(MODE_EDGE, 1022, 0);
    queue_item(MODE_EDGE, 1023, 1500);
    queue_item(MODE_ROW, 1023, 5);
    queue_item(MODE_ROW, 129, 0);
    queue_item(MODE_RUN, 1023, 2047);
    queue_item(MODE_READ, 0, 0);
    queue_item(MODE_READ, 1023, 2047);
    wait_idle();
    write_reg(CFG_DAMPING, 16'hFFFF);
    write_reg(CFG_ITER_LIM, 16'hFFFF);
    queue_item(MODE_RUN, 0, 0);
    queue_item(MODE_READ, 0, 0);
    wait_idle();
    // Descending offsets give node 0 no out-edges.
    write_reg(CFG_NODES, 2);
    write_reg(CFG_ITER_LIM, 4);
    write_reg(CFG_TOLERANCE, 0);
    queue_item(MODE_ROW, 0, 5);
    queue_item(MODE_ROW, 1, 3);
    queue_item(MODE_ROW, 2, 5);
    queue_item(MODE_EDGE, 3, 1);
    queue_item(MODE_EDGE, 4, 0);
    queue_item(MODE_RUN, 0, 0);
    queue_item(MODE_READ, 0, 0);
    queue_item(MODE_READ, 1, 0);
    queue_item(MODE_READ, 2, 0);
    wait_idle();
  endtask

  // Node count above the table size acts as the full table.
  task automatic test_full_nodes();
    write_reg(CFG_NODES, 255);
    write_reg(CFG_ITER_LIM, 2);
    write_reg(CFG_DAMPING, $urandom_range(0, 65535));
    load_graph(NODES_MAX, 1);
    queue_item(MODE_RUN, 0, 0);
    queue_reads(12);
    queue_item(MODE_READ, 127, 0);
    wait_idle();
    write_reg(CFG_NODES, 128);
    queue_item(MODE_RUN, 0, 0);
    queue_reads(4);
    wait_idle();
  endtask

  // Random settings, graphs, runs and reads, with some stray items mixed in.
  task automatic test_random_graphs(int rounds);
    int n;
    repeat (rounds) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_DAMPING, 0);
        1:       write_reg(CFG_DAMPING, 16'hFFFF);
        default: write_reg(CFG_DAMPING, $urandom_range(0, 65535));
      endcase
      write_reg(CFG_NODES, n);
      write_reg(CFG_ITER_LIM, $urandom_range(1, 40));
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_TOLERANCE, 0);
        1:       write_reg(CFG_TOLERANCE, $urandom_range(0, 2000000));
        2:       write_reg(CFG_TOLERANCE, {8'($urandom_range(0, 255)), $urandom()});
        default: write_reg(CFG_TOLERANCE, 1099512);
      endcase
      load_graph(n, 3);
      if ($urandom_range(0, 2) == 0)
        queue_item(MODE_ROW, $urandom_range(129, 1023), $urandom_range(0, 2047));
      queue_item(MODE_RUN, $urandom_range(0, 1023), $urandom_range(0, 2047));
      queue_reads(n + 2);
      if ($urandom_range(0, 3) == 0) queue_item(MODE_RUN, 0, 0);
      wait_idle();
    end
  endtask

  initial begin
    damp_reg = 16'd55706;
    nodes_reg = 8'd100;
    limit_reg = 16'd1000;
    tol_reg = 40'd1099512;
    last_iters = '0;
    last_conv = 1'b0;
    plan_nodes = 100;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_regs();
    test_corner_cases();
    test_full_nodes();
    test_random_graphs(4);
    quiet = 1'b1;
    test_random_graphs(2);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
